@@ hw/rtl/lru_kv_pkg.sv @@
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Shared widths, reset values and codes for the LRU key-value cache.
// ----------------------------------------------------------------------------
`default_nettype none

package lru_kv_pkg;

   localparam int unsigned ENTRIES_DEFAULT = 16;
   localparam int unsigned DATA_W          = 32;
   localparam int unsigned CAP_W           = 5;

   localparam logic [CAP_W-1:0]  CAPACITY_RESET = CAP_W'(16);
   localparam logic [DATA_W-1:0] MISS_VALUE     = {DATA_W{1'b1}};
   localparam logic [DATA_W-1:0] PUT_VALUE      = {DATA_W{1'b0}};

   typedef enum logic {
      ACT_GET = 1'b0,
      ACT_PUT = 1'b1
   } action_type;

endpackage

`default_nettype wire

@@ hw/rtl/lru_kv_req_if.sv @@
// ----------------------------------------------------------------------------
// LRU key-value cache request channel
// Valid/ready channel carrying one get or put access.
// ----------------------------------------------------------------------------
`default_nettype none

interface lru_kv_req_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   action;
   logic signed [lru_kv_pkg::DATA_W-1:0]   key;
   logic signed [lru_kv_pkg::DATA_W-1:0]   value;

   modport source (output valid, output action, output key, output value, input ready);
   modport sink   (input valid, input action, input key, input value, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/lru_kv_rsp_if.sv @@
// ----------------------------------------------------------------------------
// LRU key-value cache response channel
// Valid/ready channel carrying the result of one access.
// ----------------------------------------------------------------------------
`default_nettype none

interface lru_kv_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   hit;
   logic signed [lru_kv_pkg::DATA_W-1:0]   read_value;

   modport source (output valid, output hit, output read_value, input ready);
   modport sink   (input valid, input hit, input read_value, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/lru_kv_tags.sv @@
// ----------------------------------------------------------------------------
// LRU key-value cache tag array
// Stored keys and valid bits with a parallel compare against the lookup key.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_kv_tags #(
   parameter int unsigned ENTRIES = lru_kv_pkg::ENTRIES_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [lru_kv_pkg::DATA_W-1:0]     lookup_key,
   input  wire logic                              write_en,
   input  wire logic                              fill,
   input  wire logic [ENTRIES-1:0]                write_hot,
   output logic      [ENTRIES-1:0]                valid,
   output logic      [ENTRIES-1:0]                match_hot
);

   logic [lru_kv_pkg::DATA_W-1:0] keys_ff [ENTRIES];
   logic [ENTRIES-1:0]            valid_ff;
   logic [ENTRIES-1:0]            valid_in;

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         match_hot[i] = valid_ff[i] && (keys_ff[i] == lookup_key);
      end
   end

   assign valid    = valid_ff;
   assign valid_in = (write_en && fill) ? (valid_ff | write_hot) : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ENTRIES; i++) begin
         if (write_en && write_hot[i]) begin
            keys_ff[i] <= lookup_key;
         end
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/lru_kv_rank.sv @@
// ----------------------------------------------------------------------------
// LRU key-value cache recency tracker
// Per-entry recency rank (0 = most recent) and occupancy count.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_kv_rank #(
   parameter int unsigned ENTRIES = lru_kv_pkg::ENTRIES_DEFAULT,
   localparam int unsigned RANK_W = $clog2(ENTRIES),
   localparam int unsigned OCC_W  = $clog2(ENTRIES + 1)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [ENTRIES-1:0]   valid,
   input  wire logic                 touch,
   input  wire logic                 fill,
   input  wire logic [ENTRIES-1:0]   target_hot,
   output logic      [OCC_W-1:0]     occupancy,
   output logic      [ENTRIES-1:0]   lru_hot
);

   logic [RANK_W-1:0] rank_ff [ENTRIES];
   logic [RANK_W-1:0] rank_in [ENTRIES];
   logic [OCC_W-1:0]  occ_ff;
   logic [OCC_W-1:0]  occ_in;
   logic [RANK_W-1:0] target_rank;
   logic [OCC_W-1:0]  threshold;

   always_comb begin
      target_rank = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (target_hot[i]) begin
            target_rank = target_rank | rank_ff[i];
         end
         lru_hot[i] = valid[i] && ((OCC_W'(rank_ff[i]) + OCC_W'(1)) == occ_ff);
      end
   end

   // a new entry ages every valid entry, a reused one only those more recent
   assign threshold = fill ? occ_ff : OCC_W'(target_rank);

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         rank_in[i] = rank_ff[i];
         if (touch) begin
            if (target_hot[i]) begin
               rank_in[i] = '0;
            end else if (valid[i] && (OCC_W'(rank_ff[i]) < threshold)) begin
               rank_in[i] = rank_ff[i] + RANK_W'(1);
            end
         end
      end
      occ_in = (touch && fill) ? occ_ff + OCC_W'(1) : occ_ff;
   end

   assign occupancy = occ_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         occ_ff <= occ_in;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/lru_key_value_cache.sv @@
// ----------------------------------------------------------------------------
// LRU key-value cache
// Fully associative key-value store with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one access per transfer: action (get or put), key and value.
//   rsp returns one result per access, in order: hit, and read_value (the
//   stored value on a get hit, -1 on a get miss, 0 for every put).
//   csr_wr_en/csr_wr_data set the capacity; write it only while idle.
//   Zero counts as one and values above ENTRIES count as ENTRIES.
// Timing:
//   An accepted access waits in the input register, where the parallel key
//   compare, rank update and value memory read happen; it moves on to the
//   result register when rsp is not stalled, and rsp valid is driven from
//   the result register. Throughput one access per cycle while rsp is not
//   stalled.
// Reset:
//   All valid bits, ranks and occupancy clear at once and capacity returns to
//   16; there is no clearing pass. When rsp stalls, the result holds and the
//   input register still takes one more access before req deasserts ready.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache #(
   parameter int unsigned ENTRIES = lru_kv_pkg::ENTRIES_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire logic [lru_kv_pkg::CAP_W-1:0]  csr_wr_data,
   lru_kv_req_if.sink                         req,
   lru_kv_rsp_if.source                       rsp
);

   localparam int unsigned IDX_W = $clog2(ENTRIES);
   localparam int unsigned OCC_W = $clog2(ENTRIES + 1);
   localparam int unsigned CMP_W = (OCC_W > lru_kv_pkg::CAP_W) ? OCC_W : lru_kv_pkg::CAP_W;

   // configuration
   logic [lru_kv_pkg::CAP_W-1:0] cap_ff;

   // input register
   logic                            in_valid_ff;
   lru_kv_pkg::action_type          action_ff;
   logic [lru_kv_pkg::DATA_W-1:0]   key_ff;
   logic [lru_kv_pkg::DATA_W-1:0]   value_ff;

   // result register
   logic                            rsp_valid_ff;
   logic                            rsp_hit_ff;
   logic                            rsp_put_ff;
   logic [lru_kv_pkg::DATA_W-1:0]   read_data_ff;

   logic [lru_kv_pkg::DATA_W-1:0]   value_mem [ENTRIES];

   logic                 advance;
   logic [ENTRIES-1:0]   valid;
   logic [ENTRIES-1:0]   match_hot;
   logic [ENTRIES-1:0]   free_hot;
   logic [ENTRIES-1:0]   lru_hot;
   logic [ENTRIES-1:0]   target_hot;
   logic [ENTRIES-1:0]   invalid;
   logic [OCC_W-1:0]     occupancy;
   logic [CMP_W-1:0]     eff_cap;
   logic                 hit;
   logic                 is_put;
   logic                 fill;
   logic                 touch;
   logic                 key_write;
   logic [IDX_W-1:0]     target_idx;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;

   assign hit    = |match_hot;
   assign is_put = (action_ff == lru_kv_pkg::ACT_PUT);

   // first free entry: isolate the lowest set bit of the invalid mask
   assign invalid  = ~valid;
   assign free_hot = invalid & (~invalid + ENTRIES'(1));

   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = CMP_W'(1);
      end else if (CMP_W'(cap_ff) > CMP_W'(ENTRIES)) begin
         eff_cap = CMP_W'(ENTRIES);
      end else begin
         eff_cap = CMP_W'(cap_ff);
      end
   end

   assign fill       = is_put && !hit && (CMP_W'(occupancy) < eff_cap);
   assign target_hot = hit ? match_hot : (fill ? free_hot : lru_hot);
   assign touch      = advance && (hit || is_put);
   assign key_write  = advance && is_put && !hit;

   always_comb begin
      target_idx = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (target_hot[i]) begin
            target_idx = target_idx | IDX_W'(i);
         end
      end
   end

   lru_kv_tags #(
      .ENTRIES (ENTRIES)
   ) u_tags (
      .clock      (clock),
      .reset      (reset),
      .lookup_key (key_ff),
      .write_en   (key_write),
      .fill       (fill),
      .write_hot  (target_hot),
      .valid      (valid),
      .match_hot  (match_hot)
   );

   lru_kv_rank #(
      .ENTRIES (ENTRIES)
   ) u_rank (
      .clock      (clock),
      .reset      (reset),
      .valid      (valid),
      .touch      (touch),
      .fill       (fill),
      .target_hot (target_hot),
      .occupancy  (occupancy),
      .lru_hot    (lru_hot)
   );

   always_ff @(posedge clock) begin
      if (advance && is_put) begin
         value_mem[target_idx] <= value_ff;
      end
      if (advance) begin
         read_data_ff <= value_mem[target_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= lru_kv_pkg::CAPACITY_RESET;
      end else if (csr_wr_en) begin
         cap_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         action_ff <= lru_kv_pkg::action_type'(req.action);
         key_ff    <= req.key;
         value_ff  <= req.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_hit_ff <= hit;
         rsp_put_ff <= is_put;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.hit        = rsp_hit_ff;
   assign rsp.read_value = rsp_put_ff ? lru_kv_pkg::PUT_VALUE :
                           (rsp_hit_ff ? read_data_ff : lru_kv_pkg::MISS_VALUE);

endmodule

`default_nettype wire
